FILE: hdl/apf_pkg.sv
`timescale 1ns / 1ps

package apf_pkg;

    // framing constants
    localparam int          HEADER_BYTES     = 5;
    localparam int          HDR_IDX_W        = 3;
    localparam logic [6:0]  TICKS_PER_SECOND = 7'd100;
    localparam logic [7:0]  START_CHAR       = 8'h23;
    localparam logic [7:0]  IDLE_MAX         = 8'hFF;
    localparam logic [7:0]  HDR_LEN_POS      = 8'd5;

    // configuration register indexes
    localparam logic [1:0]  REG_POLL_INTERVAL = 2'd0;
    localparam logic [1:0]  REG_ADDR_PREFIX   = 2'd1;
    localparam logic [1:0]  REG_UNIT_SERIAL   = 2'd2;
    localparam logic [1:0]  REG_IDLE_LIMIT    = 2'd3;

    // result kinds
    localparam logic        KIND_POLL   = 1'b0;
    localparam logic        KIND_PACKET = 1'b1;

    // input operation codes
    typedef enum logic [1:0] {
        OP_TICK    = 2'd0,
        OP_BYTE    = 2'd1,
        OP_RELEASE = 2'd2
    } t_op;

    // work items handed from front to back
    typedef enum logic [1:0] {
        CMD_POLL   = 2'd0,
        CMD_HEADER = 2'd1,
        CMD_DATA   = 2'd2
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind                      kind;
        logic [HEADER_BYTES-1:0][7:0]   bytes;
        logic [7:0]                     pos;
        logic                           pkt_end;
    } t_cmd;

    // configuration seen by the front
    typedef struct packed {
        logic [15:0] poll_interval;
        logic [7:0]  addr_prefix;
        logic [15:0] unit_serial;
        logic [7:0]  idle_limit;
    } t_cfg;

endpackage

FILE: hdl/apf_queue.sv
`timescale 1ns / 1ps

module apf_queue
    import apf_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_cmd o_cmd
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_cmd             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             w_push;
    logic             w_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    // storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

FILE: hdl/apf_front.sv
`timescale 1ns / 1ps

module apf_front
    import apf_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [1:0] i_op,
    input  logic [7:0] i_byte,
    output logic       o_ready,
    input  t_cfg       i_cfg,
    input  logic       i_full,
    output logic       o_push,
    output t_cmd       o_cmd
);

    logic [6:0]                   r_tick, n_tick;
    logic [15:0]                  r_secs, n_secs;
    logic [7:0]                   r_idle, n_idle;
    logic [HEADER_BYTES-1:0][7:0] r_win, n_win;
    logic [7:0]                   r_pos, n_pos;
    logic                         r_ready, n_ready;
    logic [7:0]                   r_len, n_len;

    logic       w_accept;
    logic [6:0] w_tick_inc;
    logic [15:0] w_secs_inc;
    logic [7:0] w_pos0;
    logic [7:0] w_pos_inc;
    logic       w_match;

    assign o_ready  = !i_full;
    assign w_accept = i_valid && !i_full;

    // classify the item and work out the next state
    always_comb begin
        n_tick     = r_tick;
        n_secs     = r_secs;
        n_idle     = r_idle;
        n_win      = r_win;
        n_pos      = r_pos;
        n_ready    = r_ready;
        n_len      = r_len;
        o_push     = 1'b0;
        o_cmd      = '0;
        w_tick_inc = r_tick + 1'b1;
        w_secs_inc = r_secs + 1'b1;
        w_pos0     = (r_idle > i_cfg.idle_limit) ? '0 : r_pos;
        w_pos_inc  = w_pos0 + 1'b1;
        w_match    = 1'b0;
        if (w_accept) begin
            case (t_op'(i_op))
                OP_TICK: begin
                    if (w_tick_inc == TICKS_PER_SECOND) begin
                        n_tick = '0;
                        if (w_secs_inc >= i_cfg.poll_interval) begin
                            n_secs     = '0;
                            o_push     = 1'b1;
                            o_cmd.kind = CMD_POLL;
                        end else begin
                            n_secs = w_secs_inc;
                        end
                    end else begin
                        n_tick = w_tick_inc;
                    end
                    if (r_idle != IDLE_MAX) begin
                        n_idle = r_idle + 1'b1;
                    end
                end
                OP_BYTE: begin
                    if (!r_ready) begin
                        n_idle = '0;
                        if (w_pos0 == '0) begin
                            // hunting: slide the header window
                            for (int i = 0; i < HEADER_BYTES - 1; i++) begin
                                n_win[i] = r_win[i+1];
                            end
                            n_win[HEADER_BYTES-1] = i_byte;
                            w_match = (n_win[0] == START_CHAR)
                                   && (n_win[1] == i_cfg.addr_prefix)
                                   && ({n_win[2], n_win[3]} == i_cfg.unit_serial);
                            if (w_match) begin
                                o_push      = 1'b1;
                                o_cmd.kind  = CMD_HEADER;
                                o_cmd.bytes = n_win;
                                n_len       = n_win[HEADER_BYTES-1];
                                n_pos       = HDR_LEN_POS;
                            end else begin
                                n_pos = w_pos0;
                            end
                        end else begin
                            // assembling: pass the byte on
                            n_pos          = w_pos_inc;
                            n_ready        = (w_pos_inc == r_len);
                            o_push         = 1'b1;
                            o_cmd.kind     = CMD_DATA;
                            o_cmd.bytes[0] = i_byte;
                            o_cmd.pos      = w_pos0;
                            o_cmd.pkt_end  = (w_pos_inc == r_len);
                        end
                    end
                end
                OP_RELEASE: begin
                    n_ready = 1'b0;
                    n_pos   = '0;
                end
                default: begin
                end
            endcase
        end
    end

    // framer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick  <= '0;
            r_secs  <= '0;
            r_idle  <= '0;
            r_win   <= '0;
            r_pos   <= '0;
            r_ready <= 1'b0;
            r_len   <= '0;
        end else begin
            r_tick  <= n_tick;
            r_secs  <= n_secs;
            r_idle  <= n_idle;
            r_win   <= n_win;
            r_pos   <= n_pos;
            r_ready <= n_ready;
            r_len   <= n_len;
        end
    end

endmodule

FILE: hdl/apf_back.sv
`timescale 1ns / 1ps

module apf_back
    import apf_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_empty,
    input  t_cmd       i_cmd,
    output logic       o_pop,
    output logic       o_valid,
    input  logic       i_ready,
    output logic       o_kind,
    output logic [7:0] o_value,
    output logic [7:0] o_pos,
    output logic       o_end,
    output logic       o_last
);

    logic                 r_valid;
    logic [HDR_IDX_W-1:0] r_idx;
    logic                 r_kind;
    logic [7:0]           r_value;
    logic [7:0]           r_pos;
    logic                 r_end;
    logic                 r_last;

    logic       w_load;
    logic       w_kind;
    logic [7:0] w_value;
    logic [7:0] w_pos;
    logic       w_end;
    logic       w_last;

    assign w_load  = !r_valid || i_ready;
    assign o_pop   = w_load && !i_empty && w_last;
    assign o_valid = r_valid;
    assign o_kind  = r_kind;
    assign o_value = r_value;
    assign o_pos   = r_pos;
    assign o_end   = r_end;
    assign o_last  = r_last;

    // result for the head work item at the current header index
    always_comb begin
        w_kind  = KIND_PACKET;
        w_value = '0;
        w_pos   = '0;
        w_end   = 1'b0;
        w_last  = 1'b1;
        case (i_cmd.kind)
            CMD_POLL: begin
                w_kind = KIND_POLL;
            end
            CMD_HEADER: begin
                w_value = i_cmd.bytes[r_idx];
                w_pos   = 8'(r_idx);
                w_last  = (r_idx == HDR_IDX_W'(HEADER_BYTES - 1));
            end
            CMD_DATA: begin
                w_value = i_cmd.bytes[0];
                w_pos   = i_cmd.pos;
                w_end   = i_cmd.pkt_end;
            end
            default: begin
            end
        endcase
    end

    // output register and header index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (w_load) begin
            r_valid <= !i_empty;
            if (!i_empty) begin
                r_idx <= w_last ? '0 : r_idx + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load && !i_empty) begin
            r_kind  <= w_kind;
            r_value <= w_value;
            r_pos   <= w_pos;
            r_end   <= w_end;
            r_last  <= w_last;
        end
    end

endmodule

FILE: hdl/addressed_packet_framer_with_timeout.sv
`timescale 1ns / 1ps

// channel   direction  signals                 contents
// s_axis    in         tvalid/tready/tdata/tuser  tuser: operation, tdata: rx_byte
// m_axis    out        tvalid/tready/tdata/tuser/tlast
//                                               tuser: kind, tlast: run_last,
//                                               tdata: byte_value, position, end
// apb       in/out     psel/penable/pwrite/paddr/pwdata/prdata/pready
//
// the front takes one item per cycle while the work queue has room
// a header match gives five results, any other work item one result
// the output register drains one result per cycle while m_axis_tready is high;
// queue depth sets how far the front can run ahead of a stalled output
// synchronous active-low reset clears the framer state, queue and output valid

module addressed_packet_framer_with_timeout
    import apf_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    input  logic [1:0]  s_axis_tuser,   // [1:0] operation
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [7:0] byte_value, [15:8] byte_position,
                                        // [16] packet_end, [23:17] zero
    output logic        m_axis_tuser,   // [0] kind
    output logic        m_axis_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    t_cfg       r_cfg;
    logic       w_full;
    logic       w_empty;
    logic       w_push;
    logic       w_pop;
    t_cmd       w_push_cmd;
    t_cmd       w_head_cmd;
    logic [7:0] w_value;
    logic [7:0] w_pos;
    logic       w_end;
    logic [1:0] w_reg;

    assign pready = 1'b1;
    assign w_reg  = paddr[3:2];

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.poll_interval <= '0;
            r_cfg.addr_prefix   <= '0;
            r_cfg.unit_serial   <= '0;
            r_cfg.idle_limit    <= 8'd10;
        end else if (psel && penable && pwrite) begin
            case (w_reg)
                REG_POLL_INTERVAL: r_cfg.poll_interval <= pwdata[15:0];
                REG_ADDR_PREFIX:   r_cfg.addr_prefix   <= pwdata[7:0];
                REG_UNIT_SERIAL:   r_cfg.unit_serial   <= pwdata[15:0];
                REG_IDLE_LIMIT:    r_cfg.idle_limit    <= pwdata[7:0];
                default: begin
                end
            endcase
        end
    end

    // register read back
    always_comb begin
        case (w_reg)
            REG_POLL_INTERVAL: prdata = {16'd0, r_cfg.poll_interval};
            REG_ADDR_PREFIX:   prdata = {24'd0, r_cfg.addr_prefix};
            REG_UNIT_SERIAL:   prdata = {16'd0, r_cfg.unit_serial};
            REG_IDLE_LIMIT:    prdata = {24'd0, r_cfg.idle_limit};
            default:           prdata = '0;
        endcase
    end

    apf_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .i_op    (s_axis_tuser),
        .i_byte  (s_axis_tdata),
        .o_ready (s_axis_tready),
        .i_cfg   (r_cfg),
        .i_full  (w_full),
        .o_push  (w_push),
        .o_cmd   (w_push_cmd)
    );

    apf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_cmd   (w_head_cmd)
    );

    apf_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (w_empty),
        .i_cmd   (w_head_cmd),
        .o_pop   (w_pop),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_kind  (m_axis_tuser),
        .o_value (w_value),
        .o_pos   (w_pos),
        .o_end   (w_end),
        .o_last  (m_axis_tlast)
    );

    assign m_axis_tdata = {7'd0, w_end, w_pos, w_value};

    // the front never pushes into a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_full)
        else $error("work item pushed into full queue");

    // a poll request is always a single-result run with empty payload
    a_poll_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser == KIND_POLL))
            |-> (m_axis_tlast && (m_axis_tdata == '0)))
        else $error("malformed poll result");

    // results before the end of a run are header bytes and never end a packet
    a_header_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tlast)
            |-> ((m_axis_tuser == KIND_PACKET) && !m_axis_tdata[16]
                 && (m_axis_tdata[15:8] < 8'(HEADER_BYTES - 1))))
        else $error("bad header byte result");

    // the queue is only popped while the output register takes a result
    a_pop_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |=> m_axis_tvalid)
        else $error("queue popped without a result");

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps

module tb;
    import apf_pkg::*;

    localparam logic [1:0] OP_UNUSED      = 2'd3;
    localparam int         WATCHDOG_LIMIT = 2000;
    localparam int         SETTLE_CYCLES  = 40;
    localparam int         REPORT_LIMIT   = 10;

    // one result as the framer should produce it
    typedef struct {
        logic       kind;
        logic [7:0] value;
        logic [7:0] pos;
        logic       pkt_end;
        logic       last;
    } t_framer_out;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = 8'h00;   // [7:0] rx_byte
    logic [1:0]  s_axis_tuser  = 2'd0;    // [1:0] operation
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;            // [7:0] byte_value, [15:8] byte_position,
                                          // [16] packet_end, [23:17] zero
    logic        m_axis_tuser;            // [0] kind
    logic        m_axis_tlast;
    logic        psel          = 1'b0;
    logic        penable       = 1'b0;
    logic        pwrite        = 1'b0;
    logic [3:0]  paddr         = 4'd0;
    logic [31:0] pwdata        = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    // framer state mirror
    logic [15:0] cfg_poll_interval = 16'd0;
    logic [7:0]  cfg_prefix        = 8'd0;
    logic [15:0] cfg_serial        = 16'd0;
    logic [7:0]  cfg_idle_limit    = 8'd10;
    logic [6:0]  tick_cnt          = 7'd0;
    logic [15:0] sec_cnt           = 16'd0;
    logic [7:0]  idle_cnt          = 8'd0;
    logic [7:0]  hdr_win [HEADER_BYTES];
    logic [7:0]  asm_pos           = 8'd0;
    logic        pkt_ready         = 1'b0;
    logic [7:0]  pkt_len           = 8'd0;

    t_framer_out pending_outputs [$];
    int          error_count   = 0;
    int          items_sent    = 0;
    bit          send_quiet    = 1'b0;
    bit          recv_quiet    = 1'b0;
    int unsigned rx_stall_left = 0;

    addressed_packet_framer_with_timeout DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic void note_failure(string msg);
        if (error_count < REPORT_LIMIT) begin
            $display("mismatch: %s", msg);
        end
        error_count++;
    endfunction

    function automatic void push_output(logic kind, logic [7:0] value, logic [7:0] pos,
                                        logic pkt_end, logic last);
        t_framer_out o;
        o.kind    = kind;
        o.value   = value;
        o.pos     = pos;
        o.pkt_end = pkt_end;
        o.last    = last;
        pending_outputs.push_back(o);
    endfunction

    // advance the framer mirror by one item and queue what it emits
    function automatic void predict_framer_outputs(logic [1:0] op, logic [7:0] data);
        logic [7:0] cur_pos;
        logic       at_end;
        case (op)
            OP_TICK: begin
                tick_cnt = tick_cnt + 7'd1;
                if (tick_cnt == TICKS_PER_SECOND) begin
                    tick_cnt = 7'd0;
                    sec_cnt  = sec_cnt + 16'd1;
                    if (sec_cnt >= cfg_poll_interval) begin
                        sec_cnt = 16'd0;
                        push_output(KIND_POLL, 8'd0, 8'd0, 1'b0, 1'b1);
                    end
                end
                if (idle_cnt != IDLE_MAX) begin
                    idle_cnt = idle_cnt + 8'd1;
                end
            end
            OP_BYTE: begin
                if (!pkt_ready) begin
                    if (idle_cnt > cfg_idle_limit) begin
                        asm_pos = 8'd0;
                    end
                    idle_cnt = 8'd0;
                    if (asm_pos == 8'd0) begin
                        // hunting: slide the header window
                        for (int i = 0; i < HEADER_BYTES - 1; i++) begin
                            hdr_win[i] = hdr_win[i+1];
                        end
                        hdr_win[HEADER_BYTES-1] = data;
                        if (hdr_win[0] == START_CHAR && hdr_win[1] == cfg_prefix &&
                            {hdr_win[2], hdr_win[3]} == cfg_serial) begin
                            for (int i = 0; i < HEADER_BYTES; i++) begin
                                push_output(KIND_PACKET, hdr_win[i], 8'(i), 1'b0,
                                            i == HEADER_BYTES - 1);
                            end
                            pkt_len = hdr_win[HEADER_BYTES-1];
                            asm_pos = 8'(HEADER_BYTES);
                        end
                    end else begin
                        cur_pos = asm_pos;
                        asm_pos = asm_pos + 8'd1;
                        at_end  = (asm_pos == pkt_len);
                        if (at_end) begin
                            pkt_ready = 1'b1;
                        end
                        push_output(KIND_PACKET, data, cur_pos, at_end, 1'b1);
                    end
                end
            end
            OP_RELEASE: begin
                pkt_ready = 1'b0;
                asm_pos   = 8'd0;
            end
            default: ;
        endcase
    endfunction

    // one input transfer with a random lead-in gap; returns at the accepting edge
    task automatic send_item(input logic [1:0] op, input logic [7:0] data);
        int unsigned gap;
        if ($urandom_range(0, 19) == 0) begin
            send_quiet = !send_quiet;
        end
        gap = send_quiet ? 0 : $urandom_range(0, 12);
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= data;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predict_framer_outputs(op, data);
        items_sent++;
    endtask

    task automatic send_byte(input logic [7:0] data);
        send_item(OP_BYTE, data);
    endtask

    task automatic send_ticks(input int count);
        for (int i = 0; i < count; i++) begin
            send_item(OP_TICK, 8'($urandom_range(0, 255)));
        end
    endtask

    task automatic send_header(input logic [7:0] len);
        send_byte(START_CHAR);
        send_byte(cfg_prefix);
        send_byte(cfg_serial[15:8]);
        send_byte(cfg_serial[7:0]);
        send_byte(len);
    endtask

    task automatic send_data(input int count);
        for (int i = 0; i < count; i++) begin
            send_byte(8'($urandom_range(0, 255)));
        end
    endtask

    // stop sending, let every expected result arrive, then let the block settle
    task automatic wait_until_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_outputs.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // apb write: setup then access
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        case (idx)
            REG_POLL_INTERVAL: cfg_poll_interval = value[15:0];
            REG_ADDR_PREFIX:   cfg_prefix        = value[7:0];
            REG_UNIT_SERIAL:   cfg_serial        = value[15:0];
            REG_IDLE_LIMIT:    cfg_idle_limit    = value[7:0];
            default: ;
        endcase
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // header match at the field extremes, discard while ready, release, bad header
    task automatic test_framing_directed();
        wait_until_drained();
        write_reg(REG_POLL_INTERVAL, 32'd0);
        write_reg(REG_ADDR_PREFIX, 32'hFF);
        write_reg(REG_UNIT_SERIAL, 32'hFFFF);
        write_reg(REG_IDLE_LIMIT, 32'd254);
        send_byte(8'h00);
        send_header(8'd7);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(8'h5A);
        send_item(OP_UNUSED, 8'hFF);
        send_item(OP_TICK, 8'hA5);
        send_item(OP_RELEASE, 8'h00);
        send_byte(START_CHAR);
        send_byte(8'hFF);
        send_byte(8'hFF);
        send_byte(8'hFE);
        send_byte(8'd9);
        send_header(8'd6);
        send_byte(8'h81);
        send_item(OP_RELEASE, 8'hFF);
    endtask

    // silence longer than the idle limit restarts hunting
    task automatic test_idle_restart();
        wait_until_drained();
        write_reg(REG_ADDR_PREFIX, 32'd0);
        write_reg(REG_UNIT_SERIAL, 32'd0);
        write_reg(REG_IDLE_LIMIT, 32'd0);
        send_header(8'd20);
        send_byte(8'h11);
        send_ticks(1);
        send_header(8'd20);
        send_byte(8'h22);
        wait_until_drained();
        write_reg(REG_IDLE_LIMIT, 32'd1);
        send_ticks(1);
        send_byte(8'h33);
        send_ticks(2);
        send_byte(8'h44);
        send_item(OP_RELEASE, 8'h00);
    endtask

    // a full second of ticks raises a poll request in the middle of a packet
    task automatic test_poll_timer();
        wait_until_drained();
        write_reg(REG_POLL_INTERVAL, 32'd0);
        write_reg(REG_IDLE_LIMIT, 32'd255);
        send_header(8'd10);
        send_ticks(101);
        send_data(5);
        send_item(OP_RELEASE, 8'h00);
    endtask

    // random phases of mostly well-formed packets mixed with noise
    task automatic test_random_traffic();
        int          budget_end;
        int          pick;
        int          len;
        int          bad_idx;
        logic [7:0]  hdr [HEADER_BYTES];
        logic [31:0] idle_pick;
        for (int phase = 0; phase < 2; phase++) begin
            wait_until_drained();
            write_reg(REG_POLL_INTERVAL,
                      $urandom_range(0, 1) ? $urandom_range(0, 3) : $urandom_range(0, 65535));
            write_reg(REG_ADDR_PREFIX, $urandom_range(0, 255));
            write_reg(REG_UNIT_SERIAL, $urandom_range(0, 65535));
            case ($urandom_range(0, 3))
                0:       idle_pick = $urandom_range(0, 3);
                1:       idle_pick = $urandom_range(0, 254);
                2:       idle_pick = 32'd255;
                default: idle_pick = 32'd10;
            endcase
            write_reg(REG_IDLE_LIMIT, idle_pick);
            budget_end = items_sent + 28;
            while (items_sent < budget_end) begin
                pick = $urandom_range(0, 9);
                if (pick <= 5) begin
                    // packet with random content, sometimes cut short or overrun
                    send_data($urandom_range(0, 2));
                    len = $urandom_range(6, 16);
                    send_header(8'(len));
                    for (int i = 0; i < len - HEADER_BYTES; i++) begin
                        if ($urandom_range(0, 7) == 0) begin
                            send_ticks($urandom_range(1, 3));
                        end
                        if ($urandom_range(0, 15) != 0) begin
                            send_byte(8'($urandom_range(0, 255)));
                        end
                    end
                    send_data($urandom_range(0, 3) == 0 ? $urandom_range(1, 2) : 0);
                    if ($urandom_range(0, 5) != 0) begin
                        send_item(OP_RELEASE, 8'($urandom_range(0, 255)));
                    end
                end else if (pick == 6) begin
                    // header with one corrupted byte
                    hdr[0] = START_CHAR;
                    hdr[1] = cfg_prefix;
                    hdr[2] = cfg_serial[15:8];
                    hdr[3] = cfg_serial[7:0];
                    hdr[4] = 8'($urandom_range(6, 16));
                    bad_idx = $urandom_range(0, 3);
                    hdr[bad_idx] = hdr[bad_idx] ^ 8'($urandom_range(1, 255));
                    for (int i = 0; i < HEADER_BYTES; i++) begin
                        send_byte(hdr[i]);
                    end
                end else if (pick == 7) begin
                    send_ticks($urandom_range(1, 4));
                end else if (pick == 8) begin
                    send_item($urandom_range(0, 1) ? OP_RELEASE : OP_UNUSED,
                              8'($urandom_range(0, 255)));
                end else begin
                    send_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
                end
            end
        end
    endtask

    // result side: random stalls, compare each transfer with the oldest prediction
    always @(posedge i_clk) begin : output_checker
        t_framer_out want;
        int unsigned stall;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            rx_stall_left <= 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (pending_outputs.size() == 0) begin
                    note_failure($sformatf("unexpected result kind=%0d tdata=%h last=%0d",
                                           m_axis_tuser, m_axis_tdata, m_axis_tlast));
                end else begin
                    want = pending_outputs.pop_front();
                    if (m_axis_tuser !== want.kind || m_axis_tdata[7:0] !== want.value ||
                        m_axis_tdata[15:8] !== want.pos ||
                        m_axis_tdata[16] !== want.pkt_end ||
                        m_axis_tdata[23:17] !== 7'd0 || m_axis_tlast !== want.last) begin
                        note_failure({
                            $sformatf("exp kind=%0d val=%h pos=%0d end=%0d last=%0d",
                                      want.kind, want.value, want.pos, want.pkt_end,
                                      want.last),
                            $sformatf(", got kind=%0d tdata=%h last=%0d",
                                      m_axis_tuser, m_axis_tdata, m_axis_tlast)});
                    end
                end
                if ($urandom_range(0, 19) == 0) begin
                    recv_quiet = !recv_quiet;
                end
                stall = recv_quiet ? 0 : $urandom_range(0, 12);
                rx_stall_left <= stall;
                m_axis_tready <= (stall == 0);
            end else if (rx_stall_left > 1) begin
                rx_stall_left <= rx_stall_left - 1;
            end else begin
                rx_stall_left <= 0;
                m_axis_tready <= 1'b1;
            end
        end
    end

    // watchdog on cycles without any transfer
    initial begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                (psel && penable && pready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $display("status: fail");
        $finish;
    end

    // test sequence
    initial begin : main_sequence
        for (int i = 0; i < HEADER_BYTES; i++) begin
            hdr_win[i] = 8'h00;
        end
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_framing_directed();
        test_idle_restart();
        test_poll_timer();
        test_random_traffic();
        wait_until_drained();
        if (pending_outputs.size() != 0) begin
            note_failure($sformatf("%0d results never arrived", pending_outputs.size()));
        end
        if (error_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
